// ===== src/relu_bound_relaxation_top_assert.svh =====
// ----------------------------------------------------------------------------
// relu_bound_relaxation_top_assert.svh
// Assertion macros used by the relaxation divider; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef RELU_BOUND_RELAXATION_TOP_ASSERT_SVH
`define RELU_BOUND_RELAXATION_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rbr assertion failed");

// next-cycle implication
`define RBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rbr assertion failed");

`else

`define RBR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RBR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/rbr_pkg.sv =====
// ----------------------------------------------------------------------------
// rbr_pkg
// Types and constants of the ReLU bound relaxation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbr_pkg;

	// slope fraction bits, one quotient bit per divider stage
	localparam int SLOPE_BITS = 16;
	localparam int DIV_STAGES = SLOPE_BITS;

	typedef enum logic [1:0] {
		CLASS_ACTIVE   = 2'd0,
		CLASS_INACTIVE = 2'd1,
		CLASS_UNSTABLE = 2'd2
	} rbr_class_t;

	// input transaction
	typedef struct packed {
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic signed [31:0] lower_coef;
		logic signed [31:0] upper_coef;
	} rbr_in_t;

	// result transaction
	typedef struct packed {
		logic signed [31:0]      new_lower_coef;
		logic signed [31:0]      new_upper_coef;
		logic [30:0]             relu_lower;
		logic [30:0]             relu_upper;
		rbr_class_t              neuron_class;
		logic [SLOPE_BITS:0]     upper_slope;
	} rbr_out_t;

	// data that rides alongside the divider
	typedef struct packed {
		rbr_class_t  cls;
		logic [31:0] new_lower;
		logic [31:0] upper_val;   // coef if active, zero if inactive, max(coef,0) if unstable
		logic [30:0] relu_lower;
		logic [30:0] relu_upper;
	} rbr_side_t;

	// restoring divider working set
	typedef struct packed {
		logic [31:0]           rem;
		logic [31:0]           den;
		logic [SLOPE_BITS-1:0] quo;
	} rbr_div_t;

endpackage

`default_nettype wire

// ===== src/rbr_front.sv =====
// ----------------------------------------------------------------------------
// rbr_front
// Classifies the neuron, resolves the lower coefficient and sets up the
// slope division u / (u - l).
// ----------------------------------------------------------------------------
`default_nettype none

module rbr_front import rbr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_vld,
	input  rbr_in_t      in_item,
	output logic         vld_s1,
	output rbr_side_t    side_s1,
	output rbr_div_t     div_s1
);

	logic [32:0] diff_w;
	logic [32:0] sum_w;
	logic        active_w;
	logic        inactive_w;
	logic        half_w;
	logic [31:0] lpos_w;
	logic [31:0] upos_w;
	logic [31:0] den_w;
	rbr_side_t   side_w;
	rbr_div_t    div_w;

	// bound arithmetic in 33 bits
	assign diff_w = {in_item.upper_bound[31], in_item.upper_bound}
		- {in_item.lower_bound[31], in_item.lower_bound};
	assign sum_w  = {in_item.upper_bound[31], in_item.upper_bound}
		+ {in_item.lower_bound[31], in_item.lower_bound};

	assign active_w   = !in_item.lower_bound[31];
	assign inactive_w = in_item.upper_bound[31] || (in_item.upper_bound == 32'sd0);
	// slope above one half: u > -l
	assign half_w     = !sum_w[32] && (sum_w != 33'd0);

	assign lpos_w = in_item.lower_coef[31] ? 32'd0 : in_item.lower_coef;
	assign upos_w = in_item.upper_coef[31] ? 32'd0 : in_item.upper_coef;
	// denominator floor of one LSB
	assign den_w  = (diff_w[31:0] == 32'd0) ? 32'd1 : diff_w[31:0];

	// classification and side data
	always_comb begin
		side_w.relu_lower = (!in_item.lower_bound[31] && in_item.lower_bound != 32'sd0)
			? in_item.lower_bound[30:0] : 31'd0;
		side_w.relu_upper = (!in_item.upper_bound[31] && in_item.upper_bound != 32'sd0)
			? in_item.upper_bound[30:0] : 31'd0;
		div_w.quo = '0;
		if (active_w) begin
			side_w.cls       = CLASS_ACTIVE;
			side_w.new_lower = in_item.lower_coef;
			side_w.upper_val = in_item.upper_coef;
			div_w.rem        = 32'd0;
			div_w.den        = 32'd1;
		end else if (inactive_w) begin
			side_w.cls       = CLASS_INACTIVE;
			side_w.new_lower = 32'd0;
			side_w.upper_val = 32'd0;
			div_w.rem        = 32'd0;
			div_w.den        = 32'd1;
		end else begin
			side_w.cls       = CLASS_UNSTABLE;
			side_w.new_lower = half_w ? lpos_w : 32'd0;
			side_w.upper_val = upos_w;
			// u < d, so the first partial remainder is u itself
			div_w.rem        = in_item.upper_bound;
			div_w.den        = den_w;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		side_s1 <= side_w;
		div_s1  <= div_w;
	end

endmodule

`default_nettype wire

// ===== src/rbr_divider.sv =====
// ----------------------------------------------------------------------------
// rbr_divider
// Pipelined restoring divider, one quotient bit per stage; the side data
// travels with each stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "relu_bound_relaxation_top_assert.svh"

module rbr_divider import rbr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_vld,
	input  rbr_side_t  in_side,
	input  rbr_div_t   in_div,
	output logic       out_vld,
	output rbr_side_t  out_side,
	output rbr_div_t   out_div
);

	// one shift-and-subtract step
	function automatic rbr_div_t div_step(input rbr_div_t a);
		rbr_div_t    r;
		logic [32:0] sh;
		logic [32:0] diff;
		r    = a;
		sh   = {a.rem, 1'b0};
		diff = sh - {1'b0, a.den};
		if (!diff[32]) begin
			r.rem = diff[31:0];
			r.quo = {a.quo[SLOPE_BITS-2:0], 1'b1};
		end else begin
			r.rem = sh[31:0];
			r.quo = {a.quo[SLOPE_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	logic      vld_s  [DIV_STAGES];
	rbr_side_t side_s [DIV_STAGES];
	rbr_div_t  div_s  [DIV_STAGES];

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < DIV_STAGES; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	// stage payload: side data rides along, one quotient bit per stage
	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		div_s[0]  <= div_step(in_div);
		for (int i = 1; i < DIV_STAGES; i++) begin
			side_s[i] <= side_s[i-1];
			div_s[i]  <= div_step(div_s[i-1]);
		end
	end

	assign out_vld  = vld_s[DIV_STAGES-1];
	assign out_side = side_s[DIV_STAGES-1];
	assign out_div  = div_s[DIV_STAGES-1];

	// checks
	`RBR_ASSERT_NEXT(a_vld_enters, clk, arst_n, in_vld, vld_s[0])
	`RBR_ASSERT_NOW(a_rem_below_den, clk, arst_n, out_vld, out_div.rem < out_div.den)
	`RBR_ASSERT_NOW(a_zero_quo_stable, clk, arst_n, out_vld && out_side.cls != CLASS_UNSTABLE, out_div.quo == '0)

endmodule

`default_nettype wire

// ===== src/rbr_back.sv =====
// ----------------------------------------------------------------------------
// rbr_back
// Scales the upper coefficient by the slope for unstable neurons and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rbr_back import rbr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_vld,
	input  rbr_side_t  in_side,
	input  rbr_div_t   in_div,
	output logic       done,
	output rbr_out_t   result
);

	logic [31+SLOPE_BITS-1:0] prod_w;
	rbr_out_t                 res_w;
	logic                     done_q;
	rbr_out_t                 result_q;

	// 31 x 16 product, drop the slope fraction
	assign prod_w = in_side.upper_val[30:0] * in_div.quo;

	always_comb begin
		res_w.new_lower_coef = in_side.new_lower;
		res_w.relu_lower     = in_side.relu_lower;
		res_w.relu_upper     = in_side.relu_upper;
		res_w.neuron_class   = in_side.cls;
		if (in_side.cls == CLASS_UNSTABLE) begin
			res_w.new_upper_coef = {1'b0, prod_w[31+SLOPE_BITS-1:SLOPE_BITS]};
			res_w.upper_slope    = {1'b0, in_div.quo};
		end else begin
			res_w.new_upper_coef = in_side.upper_val;
			res_w.upper_slope    = '0;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_w;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== src/relu_bound_relaxation_top.sv =====
// ----------------------------------------------------------------------------
// relu_bound_relaxation_top
// done is registered through the front stage, 16 divider stages and the multiply stage.
// Throughput: one transaction per cycle; busy stays low, the divider is fully pipelined.
// Results are a one-cycle strobe; the receiver cannot stall the pipeline.
// Reset (arst_n low) clears all valid bits; transactions in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module relu_bound_relaxation_top import rbr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  rbr_in_t    in_item,
	output logic       done,
	output rbr_out_t   result
);

	logic      vld_s1;
	rbr_side_t side_s1;
	rbr_div_t  div_s1;
	logic      div_vld;
	rbr_side_t div_side;
	rbr_div_t  div_res;

	// never stalls
	assign busy = 1'b0;

	rbr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.in_item (in_item),
		.vld_s1  (vld_s1),
		.side_s1 (side_s1),
		.div_s1  (div_s1)
	);

	rbr_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_side  (side_s1),
		.in_div   (div_s1),
		.out_vld  (div_vld),
		.out_side (div_side),
		.out_div  (div_res)
	);

	rbr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (div_vld),
		.in_side (div_side),
		.in_div  (div_res),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== tb/relu_bound_relaxation_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relu_bound_relaxation_top_test
// Drives neuron bound/coefficient transactions into the ReLU relaxation
// pipeline and checks every result strobe, in order, against a predictor
// of the active / inactive / unstable relaxation held in the scoreboard.
// Directed corner cases come first, then random traffic under three sender
// idle profiles.
// ----------------------------------------------------------------------------

module relu_bound_relaxation_top_test import rbr_pkg::*;;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 11;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int ITEMS_PER_MODE = 520;
	localparam int MAX_REPORTS    = 10;

	// expectation store plus relaxation predictor
	class relaxation_scoreboard;
		rbr_out_t expected_q[$];
		int       mismatches;

		function new();
			mismatches = 0;
		endfunction

		function rbr_out_t predict_relaxation(rbr_in_t x);
			logic signed [63:0] lo, hi, lc, uc, span, lpos, upos, prod;
			logic [63:0]        slope;
			rbr_out_t           r;
			lo = $signed(x.lower_bound);
			hi = $signed(x.upper_bound);
			lc = $signed(x.lower_coef);
			uc = $signed(x.upper_coef);
			r = '0;
			if (lo >= 0) begin
				r.neuron_class   = CLASS_ACTIVE;
				r.new_lower_coef = lc[31:0];
				r.new_upper_coef = uc[31:0];
			end else if (hi <= 0) begin
				r.neuron_class = CLASS_INACTIVE;
			end else begin
				r.neuron_class = CLASS_UNSTABLE;
				span = hi - lo;
				if (span < 1)
					span = 1;
				slope = (hi << SLOPE_BITS) / span;
				if (slope > (64'd1 << SLOPE_BITS))
					slope = 64'd1 << SLOPE_BITS;
				lpos = (lc > 0) ? lc : 64'sd0;
				upos = (uc > 0) ? uc : 64'sd0;
				prod = (upos * $signed(slope)) >>> SLOPE_BITS;
				r.new_upper_coef = prod[31:0];
				// lower slope is one only when the exact slope is above one half
				r.new_lower_coef = (hi > -lo) ? lpos[31:0] : 32'd0;
				r.upper_slope    = slope[SLOPE_BITS:0];
			end
			r.relu_lower = (lo > 0) ? lo[30:0] : 31'd0;
			r.relu_upper = (hi > 0) ? hi[30:0] : 31'd0;
			return r;
		endfunction

		function void note_input(rbr_in_t x);
			expected_q.push_back(predict_relaxation(x));
		endfunction

		function void check_result(rbr_out_t got);
			rbr_out_t exp_r;
			bit       bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] unexpected result: nl=%h nu=%h cls=%0d", $realtime,
						got.new_lower_coef, got.new_upper_coef, got.neuron_class);
				return;
			end
			exp_r = expected_q.pop_front();
			bad = (got.new_lower_coef !== exp_r.new_lower_coef)
				|| (got.new_upper_coef !== exp_r.new_upper_coef)
				|| (got.relu_lower !== exp_r.relu_lower)
				|| (got.relu_upper !== exp_r.relu_upper)
				|| (got.neuron_class !== exp_r.neuron_class)
				|| (got.upper_slope !== exp_r.upper_slope);
			if (bad) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("[%0t] mismatch: exp nl=%h nu=%h rl=%h ru=%h cls=%0d slope=%h",
						$realtime, exp_r.new_lower_coef, exp_r.new_upper_coef,
						exp_r.relu_lower, exp_r.relu_upper, exp_r.neuron_class,
						exp_r.upper_slope);
					$display("           got nl=%h nu=%h rl=%h ru=%h cls=%0d slope=%h",
						got.new_lower_coef, got.new_upper_coef, got.relu_lower,
						got.relu_upper, got.neuron_class, got.upper_slope);
				end
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	rbr_in_t  in_item;
	rbr_out_t result;

	relaxation_scoreboard sb;

	relu_bound_relaxation_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_item (in_item),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// watchdog: too long without any transaction moving
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic rbr_in_t make_item(logic [31:0] lo, logic [31:0] hi,
			logic [31:0] lc, logic [31:0] uc);
		rbr_in_t x;
		x.lower_bound = lo;
		x.upper_bound = hi;
		x.lower_coef  = lc;
		x.upper_coef  = uc;
		return x;
	endfunction

	function automatic logic [31:0] random_coef();
		logic [31:0] c;
		case ($urandom_range(0, 7))
			6: c = $urandom_range(0, 32'h3FFFF) - 32'h20000;
			7: begin
				case ($urandom_range(0, 4))
					0: c = 32'h0000_0000;
					1: c = 32'hFFFF_FFFF;
					2: c = 32'h0000_0001;
					3: c = 32'h7FFF_FFFF;
					default: c = 32'h8000_0000;
				endcase
			end
			default: c = $urandom;
		endcase
		return c;
	endfunction

	// bounds biased toward each class, with the unstable case most common
	function automatic rbr_in_t random_item();
		logic [31:0] lo, hi, mag;
		case ($urandom_range(0, 9))
			0, 1: begin
				lo = $urandom;
				hi = $urandom;
			end
			2: begin
				lo = ($urandom >> 1) >> $urandom_range(0, 30);
				hi = $urandom;
			end
			3: begin
				lo = $urandom | 32'h8000_0000;
				hi = -($urandom >> $urandom_range(1, 31));
			end
			9: begin
				// upper close to the mirror of lower: slope near one half
				mag = $urandom >> $urandom_range(2, 31);
				if (mag == 0)
					mag = 1;
				lo = -mag;
				hi = mag + $urandom_range(0, 2) - 1;
			end
			default: begin
				lo = -($urandom >> $urandom_range(1, 31)) - 1;
				hi = $urandom >> $urandom_range(1, 31);
				if (hi == 0)
					hi = 1;
			end
		endcase
		return make_item(lo, hi, random_coef(), random_coef());
	endfunction

	// one transaction, with random sender idle cycles ahead of it
	task automatic send_transaction(input rbr_in_t item, input int idle_pct);
		bit accepted;
		accepted = 1'b0;
		@(negedge clk);
		while (int'($urandom_range(0, 99)) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		in_item <= item;
		while (!accepted) begin
			@(posedge clk);
			if (!busy) begin
				accepted = 1'b1;
				sb.note_input(item);
			end else begin
				@(negedge clk);
			end
		end
	endtask

	task automatic run_directed();
		rbr_in_t corner_q[$];
		corner_q.push_back(make_item(32'd0, 32'd100, -32'd5, -32'd7));
		corner_q.push_back(make_item(32'h0005_0000, 32'h0001_0000, 32'h7FFF_FFFF,
			32'h8000_0000));
		corner_q.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd123, -32'd456));
		corner_q.push_back(make_item(32'd1, -32'd1, 32'h8000_0000, 32'h7FFF_FFFF));
		corner_q.push_back(make_item(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1));
		corner_q.push_back(make_item(-32'd1, 32'd0, 32'd100, 32'd100));
		corner_q.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF));
		corner_q.push_back(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF));
		// tie: exact slope one half, lower coefficient goes to zero
		corner_q.push_back(make_item(-32'd1, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		corner_q.push_back(make_item(-32'd1, 32'd2, 32'h0001_0000, 32'h0001_0000));
		corner_q.push_back(make_item(-32'h0003_0000, 32'h0001_0000, -32'd1, -32'd1));
		corner_q.push_back(make_item(-32'h0001_0000, 32'h0003_0000, 32'h0005_0000,
			32'h0007_0000));
		corner_q.push_back(make_item(32'h8000_0001, 32'h7FFF_FFFF, 32'h0001_0000,
			32'h7FFF_FFFF));
		corner_q.push_back(make_item(32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		corner_q.push_back(make_item(-32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		corner_q.push_back(make_item(-32'h0001_0000, 32'h0001_0001, 32'd0, 32'd0));
		corner_q.push_back(make_item(-32'd5, 32'd3, 32'h8000_0000, 32'h7FFF_FFFF));
		corner_q.push_back(make_item(-32'd3, 32'd5, 32'hFFFF_FFFF, 32'h8000_0000));
		corner_q.push_back(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		corner_q.push_back(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
			32'hAAAA_AAAA));
		foreach (corner_q[i])
			send_transaction(corner_q[i], 0);
	endtask

	// main sequence
	initial begin
		int idle_profile[3];
		sb      = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		in_item = '0;
		idle_profile[0] = 33;
		idle_profile[1] = 47;
		idle_profile[2] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		foreach (idle_profile[p]) begin
			repeat (ITEMS_PER_MODE)
				send_transaction(random_item(), idle_profile[p]);
		end
		@(negedge clk);
		start <= 1'b0;

		// drain the pipeline, then look for stray strobes
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
